FILE: sv/bfv_pkg.sv
// ----------------------------------------------------------------------------
// bfv_pkg
// Shared types, constants and fixed-point helpers of the bias field voxel core.
// ----------------------------------------------------------------------------
`default_nettype none

package bfv_pkg;

    localparam int COEF_COUNT = 19;
    localparam int COEF_W     = 18;
    localparam int IDX_W      = 5;
    localparam int VOX_W      = 10;
    localparam int DIM_W      = 11;
    localparam int BIAS_W     = 18;
    localparam int DEG_W      = 2;
    localparam int QUO_W      = 17;
    localparam int TERM_W     = 21;
    localparam int PROD_W     = COEF_W + TERM_W;
    localparam int ACC_W      = 46;
    localparam int GRP_SIZE   = 4;
    localparam int GRP_COUNT  = (COEF_COUNT + GRP_SIZE - 1) / GRP_SIZE;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int AXES       = 3;

    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam term_t ONE_T = 21'sd65536;
    localparam acc_t  ONE_A = 46'sd65536;
    localparam acc_t  RND_17 = 46'sd65536;
    localparam logic signed [2*TERM_W-1:0] RND_16 = 42'sd32768;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGREE   = 3'd0,
        REG_MIN_BIAS = 3'd1,
        REG_MAX_BIAS = 3'd2,
        REG_DIM_X    = 3'd3,
        REG_DIM_Y    = 3'd4,
        REG_DIM_Z    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FLAG_NONE = 2'd0,
        FLAG_MIN  = 2'd1,
        FLAG_MAX  = 2'd2
    } clamp_flag_t;

    // Sideband that travels with every transaction down the pipeline
    typedef struct packed {
        logic             is_eval;
        logic [IDX_W-1:0] coef_index;
        coef_t            coef_value;
    } side_t;

    // Q1.16 product, rounded half up
    function automatic term_t mul_q16(input term_t a, input term_t b);
        logic signed [2*TERM_W-1:0] p;
        p = a * b;
        p = p + RND_16;
        return p[TERM_W+15:16];
    endfunction

    // Lowest degree at which a coefficient takes part
    function automatic logic [DEG_W-1:0] term_degree(input int i);
        if (i < 3) begin
            return 2'd1;
        end else if (i < 9) begin
            return 2'd2;
        end
        return 2'd3;
    endfunction

    // Full-weight terms count twice in the accumulator
    function automatic logic term_double(input int i);
        return (i < 3) || (i >= 6 && i < 9) || (i == COEF_COUNT - 1);
    endfunction

endpackage

`default_nettype wire

FILE: sv/bfv_coord_div.sv
// ----------------------------------------------------------------------------
// bfv_coord_div
// Pipelined restoring divider mapping voxel indices to Q1.16 coordinates,
// one quotient bit per stage for all three axes.
// ----------------------------------------------------------------------------
`default_nettype none

module bfv_coord_div #(
    parameter int DW = 11
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  bfv_pkg::side_t             in_side,
    input  wire [bfv_pkg::VOX_W-1:0]   in_vox [bfv_pkg::AXES],
    input  wire [DW-1:0]               dim [bfv_pkg::AXES],
    output logic                       out_valid,
    input  wire                        out_ready,
    output bfv_pkg::side_t             out_side,
    output bfv_pkg::term_t             out_coord [bfv_pkg::AXES]
);

    localparam int NST = bfv_pkg::QUO_W + 1;
    localparam int QW  = bfv_pkg::QUO_W;
    localparam int IW  = (DW > bfv_pkg::VOX_W) ? DW : bfv_pkg::VOX_W;

    logic           v_reg    [NST];
    bfv_pkg::side_t side_reg [NST];
    logic [DW-1:0]  rem_reg  [NST][bfv_pkg::AXES];
    logic [QW-1:0]  num_reg  [NST][bfv_pkg::AXES];
    logic [QW-1:0]  quo_reg  [NST][bfv_pkg::AXES];

    logic           rdy      [NST];
    logic [DW-1:0]  rem_next [NST][bfv_pkg::AXES];
    logic [QW-1:0]  num_next [NST][bfv_pkg::AXES];
    logic [QW-1:0]  quo_next [NST][bfv_pkg::AXES];

    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb begin
        logic [DW:0] r2;
        for (int a = 0; a < bfv_pkg::AXES; a++) begin
            // saturate the index to dim-1, numerator tail is dim/2
            if (IW'(in_vox[a]) >= IW'(dim[a])) begin
                rem_next[0][a] = dim[a] - DW'(1);
            end else begin
                rem_next[0][a] = DW'(in_vox[a]);
            end
            num_next[0][a] = QW'(dim[a] >> 1);
            quo_next[0][a] = '0;
            for (int k = 1; k < NST; k++) begin
                r2 = {rem_reg[k-1][a], num_reg[k-1][a][QW-1]};
                if (r2 >= {1'b0, dim[a]}) begin
                    rem_next[k][a] = DW'(r2 - {1'b0, dim[a]});
                    quo_next[k][a] = {quo_reg[k-1][a][QW-2:0], 1'b1};
                end else begin
                    rem_next[k][a] = r2[DW-1:0];
                    quo_next[k][a] = {quo_reg[k-1][a][QW-2:0], 1'b0};
                end
                num_next[k][a] = {num_reg[k-1][a][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            side_reg[0] <= in_side;
        end
        for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        for (int k = 0; k < NST; k++) begin
            if (rdy[k]) begin
                for (int a = 0; a < bfv_pkg::AXES; a++) begin
                    rem_reg[k][a] <= rem_next[k][a];
                    num_reg[k][a] <= num_next[k][a];
                    quo_reg[k][a] <= quo_next[k][a];
                end
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_side  = side_reg[NST-1];

    always_comb begin
        for (int a = 0; a < bfv_pkg::AXES; a++) begin
            out_coord[a] = $signed(bfv_pkg::TERM_W'(quo_reg[NST-1][a])) - bfv_pkg::ONE_T;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bfv_poly.sv
// ----------------------------------------------------------------------------
// bfv_poly
// Three-stage pipeline building the nineteen Legendre basis terms from the
// voxel coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module bfv_poly (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            in_valid,
    output logic           in_ready,
    input  bfv_pkg::side_t in_side,
    input  bfv_pkg::term_t in_coord [bfv_pkg::AXES],
    output logic           out_valid,
    input  wire            out_ready,
    output bfv_pkg::side_t out_side,
    output bfv_pkg::term_t out_terms [bfv_pkg::COEF_COUNT]
);

    localparam int NST = 3;

    logic           v_reg    [NST];
    bfv_pkg::side_t side_reg [NST];
    logic           rdy      [NST];

    // first stage: squares and pairwise products
    bfv_pkg::term_t c1_reg  [bfv_pkg::AXES];
    bfv_pkg::term_t sq1_reg [bfv_pkg::AXES];
    bfv_pkg::term_t xy1_reg, xz1_reg, yz1_reg;

    // second stage: cubes, triple product, P2
    bfv_pkg::term_t c2_reg  [bfv_pkg::AXES];
    bfv_pkg::term_t cu2_reg [bfv_pkg::AXES];
    bfv_pkg::term_t p22_reg [bfv_pkg::AXES];
    bfv_pkg::term_t xy2_reg, xz2_reg, yz2_reg, xyz2_reg;

    // third stage: full term vector
    bfv_pkg::term_t t3_reg [bfv_pkg::COEF_COUNT];

    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            side_reg[0] <= in_side;
            for (int a = 0; a < bfv_pkg::AXES; a++) begin
                c1_reg[a]  <= in_coord[a];
                sq1_reg[a] <= bfv_pkg::mul_q16(in_coord[a], in_coord[a]);
            end
            xy1_reg <= bfv_pkg::mul_q16(in_coord[0], in_coord[1]);
            xz1_reg <= bfv_pkg::mul_q16(in_coord[0], in_coord[2]);
            yz1_reg <= bfv_pkg::mul_q16(in_coord[1], in_coord[2]);
        end
        if (rdy[1]) begin
            side_reg[1] <= side_reg[0];
            for (int a = 0; a < bfv_pkg::AXES; a++) begin
                c2_reg[a]  <= c1_reg[a];
                cu2_reg[a] <= bfv_pkg::mul_q16(sq1_reg[a], c1_reg[a]);
                p22_reg[a] <= (sq1_reg[a] <<< 1) + sq1_reg[a] - bfv_pkg::ONE_T;
            end
            xy2_reg  <= xy1_reg;
            xz2_reg  <= xz1_reg;
            yz2_reg  <= yz1_reg;
            xyz2_reg <= bfv_pkg::mul_q16(xy1_reg, c1_reg[2]);
        end
        if (rdy[2]) begin
            side_reg[2] <= side_reg[1];
            for (int a = 0; a < bfv_pkg::AXES; a++) begin
                t3_reg[a]     <= c2_reg[a];
                t3_reg[3 + a] <= p22_reg[a];
                // P3 = 5*a^3 - 3*a
                t3_reg[9 + a] <= (cu2_reg[a] <<< 2) + cu2_reg[a]
                                 - ((c2_reg[a] <<< 1) + c2_reg[a]);
            end
            t3_reg[6]  <= xy2_reg;
            t3_reg[7]  <= xz2_reg;
            t3_reg[8]  <= yz2_reg;
            t3_reg[12] <= bfv_pkg::mul_q16(p22_reg[0], c2_reg[1]);
            t3_reg[13] <= bfv_pkg::mul_q16(p22_reg[0], c2_reg[2]);
            t3_reg[14] <= bfv_pkg::mul_q16(p22_reg[1], c2_reg[0]);
            t3_reg[15] <= bfv_pkg::mul_q16(p22_reg[1], c2_reg[2]);
            t3_reg[16] <= bfv_pkg::mul_q16(p22_reg[2], c2_reg[0]);
            t3_reg[17] <= bfv_pkg::mul_q16(p22_reg[2], c2_reg[1]);
            t3_reg[18] <= xyz2_reg;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_side  = side_reg[NST-1];

    always_comb begin
        for (int i = 0; i < bfv_pkg::COEF_COUNT; i++) begin
            out_terms[i] = t3_reg[i];
        end
    end

endmodule

`default_nettype wire

FILE: sv/bfv_accum.sv
// ----------------------------------------------------------------------------
// bfv_accum
// Coefficient store, coefficient products, registered adder tree, rounding
// and clamp. Loads update the store in pipeline order and drop out here.
// ----------------------------------------------------------------------------
`default_nettype none

module bfv_accum (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  bfv_pkg::side_t             in_side,
    input  bfv_pkg::term_t             in_terms [bfv_pkg::COEF_COUNT],
    input  wire [bfv_pkg::DEG_W-1:0]   degree,
    input  wire [bfv_pkg::BIAS_W-1:0]  min_bias,
    input  wire [bfv_pkg::BIAS_W-1:0]  max_bias,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [bfv_pkg::BIAS_W-1:0] out_bias,
    output logic [1:0]                 out_flag
);

    localparam int NST = 4;
    localparam int NC  = bfv_pkg::COEF_COUNT;

    logic          v_reg [NST];
    logic          rdy   [NST];

    bfv_pkg::coef_t coef_reg [NC];
    bfv_pkg::acc_t  prod_reg [NC];
    bfv_pkg::acc_t  grp_reg  [bfv_pkg::GRP_COUNT];
    bfv_pkg::acc_t  tot_reg;
    logic [bfv_pkg::BIAS_W-1:0] bias_reg;
    logic [1:0]                 flag_reg;

    bfv_pkg::acc_t  prod_next [NC];
    bfv_pkg::acc_t  grp_next  [bfv_pkg::GRP_COUNT];
    bfv_pkg::acc_t  tot_next;
    bfv_pkg::acc_t  sum_rnd;
    bfv_pkg::acc_t  min_s;
    bfv_pkg::acc_t  max_s;
    logic [bfv_pkg::BIAS_W-1:0] bias_next;
    logic [1:0]                 flag_next;
    logic                       store_wr;

    always_comb begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];
    assign store_wr = in_valid && rdy[0] && !in_side.is_eval
                      && (in_side.coef_index < bfv_pkg::IDX_W'(NC));

    // coefficient times term, doubled for full-weight terms, masked by degree
    always_comb begin
        logic signed [bfv_pkg::PROD_W-1:0] p;
        for (int i = 0; i < NC; i++) begin
            p = coef_reg[i] * in_terms[i];
            if (degree >= bfv_pkg::term_degree(i)) begin
                if (bfv_pkg::term_double(i)) begin
                    prod_next[i] = bfv_pkg::ACC_W'(p) <<< 1;
                end else begin
                    prod_next[i] = bfv_pkg::ACC_W'(p);
                end
            end else begin
                prod_next[i] = '0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < bfv_pkg::GRP_COUNT; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < bfv_pkg::GRP_SIZE; j++) begin
                if (g * bfv_pkg::GRP_SIZE + j < NC) begin
                    grp_next[g] = grp_next[g] + prod_reg[g * bfv_pkg::GRP_SIZE + j];
                end
            end
        end
        tot_next = '0;
        for (int g = 0; g < bfv_pkg::GRP_COUNT; g++) begin
            tot_next = tot_next + grp_reg[g];
        end
    end

    // round to Q.16, add one, clamp against min first
    always_comb begin
        sum_rnd = ((tot_reg + bfv_pkg::RND_17) >>> 17) + bfv_pkg::ONE_A;
        min_s   = $signed(bfv_pkg::ACC_W'(min_bias));
        max_s   = $signed(bfv_pkg::ACC_W'(max_bias));
        priority if (sum_rnd < min_s) begin
            bias_next = min_bias;
            flag_next = bfv_pkg::FLAG_MIN;
        end else if (sum_rnd > max_s) begin
            bias_next = max_bias;
            flag_next = bfv_pkg::FLAG_MAX;
        end else begin
            bias_next = sum_rnd[bfv_pkg::BIAS_W-1:0];
            flag_next = bfv_pkg::FLAG_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) begin
                v_reg[k] <= 1'b0;
            end
            for (int i = 0; i < NC; i++) begin
                coef_reg[i] <= '0;
            end
        end else begin
            if (store_wr) begin
                coef_reg[in_side.coef_index] <= in_side.coef_value;
            end
            // drop loads: only evaluate transactions go on
            if (rdy[0]) begin
                v_reg[0] <= in_valid && in_side.is_eval;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int i = 0; i < NC; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (rdy[1]) begin
            for (int g = 0; g < bfv_pkg::GRP_COUNT; g++) begin
                grp_reg[g] <= grp_next[g];
            end
        end
        if (rdy[2]) begin
            tot_reg <= tot_next;
        end
        if (rdy[3]) begin
            bias_reg <= bias_next;
            flag_reg <= flag_next;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_bias  = bias_reg;
    assign out_flag  = flag_reg;

endmodule

`default_nettype wire

FILE: sv/polynomial_bias_field_voxel_core.sv
// ----------------------------------------------------------------------------
// polynomial_bias_field_voxel_core
// Evaluates a cubic Legendre bias field at one voxel per clock cycle while
// the output is not stalled. Each transaction either loads one of 19 signed
// Q1.16 coefficients (operation 0) or evaluates a voxel (operation 1). Voxel
// indices are mapped to Q1.16 coordinates by an 18-stage divider (an index
// stage, then one quotient bit per stage). The basis terms take three
// multiplier stages, and the weighted sum, rounding and clamp take four more.
// That makes 25 register stages, and one transaction is taken every cycle
// while the output is not stalled. Loads travel the same pipeline and update
// the coefficient store in order, so an evaluate sees exactly the loads
// accepted before it. Loads give no result. Configuration (degree, clamps,
// dimensions) is to be written through the cfg port only while no transaction
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_bias_field_voxel_core #(
    parameter int MAX_DIM = 1024
) (
    input  wire                                aclk,
    input  wire                                aresetn,

    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_operation,
    input  wire [bfv_pkg::IDX_W-1:0]           s_coef_index,
    input  wire signed [bfv_pkg::COEF_W-1:0]   s_coef_value,
    input  wire [bfv_pkg::VOX_W-1:0]           s_vox_x,
    input  wire [bfv_pkg::VOX_W-1:0]           s_vox_y,
    input  wire [bfv_pkg::VOX_W-1:0]           s_vox_z,

    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [bfv_pkg::BIAS_W-1:0]         m_bias_value,
    output logic [1:0]                         m_clamp_flag,

    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [bfv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [bfv_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int EW = (DW > bfv_pkg::DIM_W) ? DW : bfv_pkg::DIM_W;

    logic [bfv_pkg::DEG_W-1:0]  degree_reg;
    logic [bfv_pkg::BIAS_W-1:0] min_bias_reg;
    logic [bfv_pkg::BIAS_W-1:0] max_bias_reg;
    logic [bfv_pkg::DIM_W-1:0]  dim_reg [bfv_pkg::AXES];

    logic [bfv_pkg::DEG_W-1:0]  degree_eff;
    logic [DW-1:0]              dim_eff [bfv_pkg::AXES];
    logic [bfv_pkg::VOX_W-1:0]  vox     [bfv_pkg::AXES];
    bfv_pkg::side_t             s_side;

    logic           div_valid, div_ready;
    bfv_pkg::side_t div_side;
    bfv_pkg::term_t div_coord [bfv_pkg::AXES];

    logic           poly_valid, poly_ready;
    bfv_pkg::side_t poly_side;
    bfv_pkg::term_t poly_terms [bfv_pkg::COEF_COUNT];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg   <= 2'd2;
            min_bias_reg <= 18'd32768;
            max_bias_reg <= 18'd163840;
            for (int a = 0; a < bfv_pkg::AXES; a++) begin
                dim_reg[a] <= 11'd256;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                bfv_pkg::REG_DEGREE:   degree_reg   <= cfg_data[bfv_pkg::DEG_W-1:0];
                bfv_pkg::REG_MIN_BIAS: min_bias_reg <= cfg_data[bfv_pkg::BIAS_W-1:0];
                bfv_pkg::REG_MAX_BIAS: max_bias_reg <= cfg_data[bfv_pkg::BIAS_W-1:0];
                bfv_pkg::REG_DIM_X:    dim_reg[0]   <= cfg_data[bfv_pkg::DIM_W-1:0];
                bfv_pkg::REG_DIM_Y:    dim_reg[1]   <= cfg_data[bfv_pkg::DIM_W-1:0];
                bfv_pkg::REG_DIM_Z:    dim_reg[2]   <= cfg_data[bfv_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // degree zero runs as linear; dimension zero as one, above MAX_DIM saturates
    always_comb begin
        logic [EW-1:0] d;
        degree_eff = (degree_reg == '0) ? bfv_pkg::DEG_W'(1) : degree_reg;
        for (int a = 0; a < bfv_pkg::AXES; a++) begin
            d = EW'(dim_reg[a]);
            if (d == '0) begin
                dim_eff[a] = DW'(1);
            end else if (d > EW'(MAX_DIM)) begin
                dim_eff[a] = DW'(MAX_DIM);
            end else begin
                dim_eff[a] = DW'(d);
            end
        end
    end

    assign vox[0] = s_vox_x;
    assign vox[1] = s_vox_y;
    assign vox[2] = s_vox_z;

    assign s_side.is_eval    = (s_operation == bfv_pkg::OP_EVAL);
    assign s_side.coef_index = s_coef_index;
    assign s_side.coef_value = s_coef_value;

    bfv_coord_div #(
        .DW(DW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_side   (s_side),
        .in_vox    (vox),
        .dim       (dim_eff),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_side  (div_side),
        .out_coord (div_coord)
    );

    bfv_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_side   (div_side),
        .in_coord  (div_coord),
        .out_valid (poly_valid),
        .out_ready (poly_ready),
        .out_side  (poly_side),
        .out_terms (poly_terms)
    );

    bfv_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (poly_valid),
        .in_ready  (poly_ready),
        .in_side   (poly_side),
        .in_terms  (poly_terms),
        .degree    (degree_eff),
        .min_bias  (min_bias_reg),
        .max_bias  (max_bias_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_bias  (m_bias_value),
        .out_flag  (m_clamp_flag)
    );

endmodule

`default_nettype wire
